@@ rtl/core/afc_pkg.sv @@
// shared types and constants for the acquisition frame checker
package afc_pkg;

	localparam logic [7:0]  HDR_MARK        = 8'hAA;
	localparam logic [7:0]  FTR_MARK        = 8'h55;
	localparam logic [15:0] RISE_THR_RESET  = 16'd128;
	localparam logic [15:0] FALL_THR_RESET  = 16'd0;

	localparam int unsigned LEN_W   = 12;
	localparam int unsigned WORDS_W = 13;
	localparam int unsigned OBJ_W   = 32;
	localparam int unsigned THR_W   = 16;
	localparam int unsigned IDX_W   = 8;

	typedef enum logic [IDX_W-1:0] {
		REG_RISE_THR = 8'd0,
		REG_FALL_THR = 8'd1
	} reg_idx_t;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_LAST = 2'd1,
		STATUS_FAIL = 2'd2
	} status_t;

	typedef struct packed {
		status_t              frame_status;
		logic [WORDS_W-1:0]   frame_words;
		logic [OBJ_W-1:0]     object_number;
	} result_t;

	typedef struct packed {
		logic [THR_W-1:0] rise;
		logic [THR_W-1:0] fall;
	} thr_t;

endpackage

@@ rtl/core/acquisition_frame_checker.sv @@
// top level of the acquisition frame checker
//
//  channel   signals                      beat carries
//  s_        s_tvalid s_tready s_tdata    one 64-bit frame word
//  m_        m_tvalid m_tready m_tdata    status, frame length, object id
//  cfg_      cfg_valid cfg_ready          register index and 16-bit value
//
// one word per cycle while no footer stalls; a footer beat passes the input register,
// then the result register, before its result is valid, and only footer words produce a beat
// cfg_ready is always high; thresholds reset to rising 128, falling 0
// m_tready low stalls the input only once a footer meets a full result register
module acquisition_frame_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [63:0]               s_tdata,   // [63:0] data_word
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [47:0]               m_tdata,   // [1:0] frame_status, [14:2] frame_words,
	                                             // [46:15] object_number, [47] zero
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [afc_pkg::IDX_W-1:0] cfg_index,
	input  logic [afc_pkg::THR_W-1:0] cfg_data
);
	import afc_pkg::*;

	thr_t    thr;
	logic    res_valid;
	logic    res_ready;
	result_t res;
	result_t out_res;

	assign cfg_ready = 1'b1;

	afc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.thr       (thr)
	);

	afc_frame_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.thr       (thr),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	afc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {1'b0, out_res.object_number, out_res.frame_words, out_res.frame_status};

endmodule

@@ rtl/core/afc_cfg_regs.sv @@
// threshold configuration registers
module afc_cfg_regs (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic [afc_pkg::IDX_W-1:0] cfg_index,
	input  logic [afc_pkg::THR_W-1:0] cfg_data,
	output afc_pkg::thr_t           thr
);
	import afc_pkg::*;

	logic [THR_W-1:0] rise_q;
	logic [THR_W-1:0] fall_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q <= RISE_THR_RESET;
			fall_q <= FALL_THR_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RISE_THR: rise_q <= cfg_data;
				REG_FALL_THR: fall_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign thr.rise = rise_q;
	assign thr.fall = fall_q;

endmodule

@@ rtl/core/afc_frame_check.sv @@
// input register, frame position tracking and per-word checks
module afc_frame_check (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [63:0]       in_data,
	input  afc_pkg::thr_t     thr,
	output logic              res_valid,
	input  logic              res_ready,
	output afc_pkg::result_t  res
);
	import afc_pkg::*;

	logic               valid_s1;
	logic [63:0]        word_s1;
	logic [WORDS_W-1:0] pos_q;
	logic [LEN_W-1:0]   len_q;
	logic [1:0]         trig_state_q;
	logic               frame_cont_q;
	logic               fault_q;

	logic               is_header;
	logic               is_footer;
	logic               thr_bad;
	logic               fault_nxt;
	logic               adv;
	logic [OBJ_W-1:0]   obj;

	always_comb begin
		is_header = (pos_q == '0);
		is_footer = !is_header && (pos_q == ({1'b0, len_q} + WORDS_W'(2)));
		thr_bad   = (pos_q == WORDS_W'(1)) &&
		            ((word_s1[31:16] != thr.rise) || (word_s1[15:0] != thr.fall));
		fault_nxt = fault_q | thr_bad;
		obj       = word_s1[OBJ_W-1:0];
		res_valid = valid_s1 && is_footer;
		adv       = valid_s1 && (!is_footer || res_ready);
		in_ready  = !valid_s1 || adv;

		res.frame_words   = {1'b0, len_q} + WORDS_W'(3);
		res.object_number = obj;
		if (fault_nxt || (word_s1[63:56] != FTR_MARK) ||
		    ((obj == '0) && (trig_state_q == 2'b11))) begin
			res.frame_status = STATUS_FAIL;
		end else if (!frame_cont_q) begin
			res.frame_status = STATUS_LAST;
		end else begin
			res.frame_status = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			len_q        <= '0;
			trig_state_q <= '0;
			frame_cont_q <= 1'b0;
			fault_q      <= 1'b0;
		end else if (adv) begin
			if (is_header) begin
				len_q        <= word_s1[43:32];
				trig_state_q <= word_s1[30:29];
				frame_cont_q <= word_s1[28];
				fault_q      <= (word_s1[63:56] != HDR_MARK);
				pos_q        <= WORDS_W'(1);
			end else if (is_footer) begin
				fault_q <= fault_nxt;
				pos_q   <= '0;
			end else begin
				fault_q <= fault_nxt;
				pos_q   <= pos_q + WORDS_W'(1);
			end
		end
	end

endmodule

@@ rtl/core/afc_out_reg.sv @@
// result register on the master side
module afc_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	output logic              res_ready,
	input  afc_pkg::result_t  res,
	output logic              out_valid,
	input  logic              out_ready,
	output afc_pkg::result_t  out_res
);
	import afc_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign res_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

@@ sim/acquisition_frame_checker_chk.sv @@
// frame checker: mirrors the frame parser on accepted beats and compares every result beat
`timescale 1ns / 100ps

module acquisition_frame_checker_chk (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [63:0]               s_tdata,   // [63:0] data_word
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [47:0]               m_tdata,   // [1:0] frame_status, [14:2] frame_words,
	                                             // [46:15] object_number, [47] zero
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [afc_pkg::IDX_W-1:0] cfg_index,
	input  logic [afc_pkg::THR_W-1:0] cfg_data,
	output int                        mismatches,
	output int                        outstanding
);
	import afc_pkg::*;

	localparam logic [7:0] TRIG_STATE_BITS = 8'h60;
	localparam logic [7:0] CONTINUE_BIT    = 8'h10;
	localparam int         REPORT_LIMIT    = 10;

	logic [WORDS_W-1:0] word_pos;
	logic [LEN_W-1:0]   payload_len;
	logic [7:0]         trig_byte;
	logic               frame_bad;
	logic [THR_W-1:0]   rise_thr;
	logic [THR_W-1:0]   fall_thr;
	result_t            frame_results_q[$];

	// takes one frame word, returns 1 when it closes the frame
	function automatic logic advance_frame(input logic [63:0] w, output result_t r);
		logic [31:0] obj;
		r = '0;
		if (word_pos == '0) begin
			payload_len = w[43:32];
			trig_byte = w[31:24];
			frame_bad = (w[63:56] != HDR_MARK);
			word_pos = 13'd1;
			return 1'b0;
		end
		if (word_pos == 13'd1) begin
			if (w[31:16] != rise_thr || w[15:0] != fall_thr)
				frame_bad = 1'b1;
		end
		if (word_pos != {1'b0, payload_len} + 13'd2) begin
			word_pos = word_pos + 13'd1;
			return 1'b0;
		end
		obj = w[31:0];
		r.frame_status = STATUS_OK;
		// trigger state only fails when the object id is zero
		if (obj == '0 && (trig_byte & TRIG_STATE_BITS) == TRIG_STATE_BITS)
			r.frame_status = STATUS_FAIL;
		else if ((trig_byte & CONTINUE_BIT) == '0)
			r.frame_status = STATUS_LAST;
		if (frame_bad || w[63:56] != FTR_MARK)
			r.frame_status = STATUS_FAIL;
		r.frame_words = {1'b0, payload_len} + 13'd3;
		r.object_number = obj;
		word_pos = '0;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t fresh;
		result_t oldest;
		if (!arst_n) begin
			word_pos = '0;
			payload_len = '0;
			trig_byte = '0;
			frame_bad = 1'b0;
			rise_thr = RISE_THR_RESET;
			fall_thr = FALL_THR_RESET;
			frame_results_q.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RISE_THR: rise_thr = cfg_data;
					REG_FALL_THR: fall_thr = cfg_data;
					default: ;
				endcase
			end
			// retire before pushing so a beat can never match the footer of this same edge
			if (m_tvalid && m_tready) begin
				if (frame_results_q.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("unexpected result beat: status %0d words %0d object %h",
							m_tdata[1:0], m_tdata[14:2], m_tdata[46:15]);
					mismatches <= mismatches + 1;
				end else begin
					oldest = frame_results_q.pop_front();
					if (m_tdata[1:0] !== oldest.frame_status ||
							m_tdata[14:2] !== oldest.frame_words ||
							m_tdata[46:15] !== oldest.object_number) begin
						if (mismatches < REPORT_LIMIT)
							$display({"result mismatch: expected status %0d words %0d object %h,",
								" got status %0d words %0d object %h"},
								oldest.frame_status, oldest.frame_words, oldest.object_number,
								m_tdata[1:0], m_tdata[14:2], m_tdata[46:15]);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (advance_frame(s_tdata, fresh))
					frame_results_q.push_back(fresh);
			end
			outstanding <= frame_results_q.size();
		end
	end

endmodule

@@ sim/acquisition_frame_checker_test.sv @@
// testbench top: clock, reset, frame stimulus, register writes and the verdict
`timescale 1ns / 100ps

module acquisition_frame_checker_test;
	import afc_pkg::*;

	localparam int IDLE_LIMIT   = 5000;
	localparam int RANDOM_ITEMS = 1200;
	localparam int PHASES       = 6;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_PERCENT = 31;
	// an index that selects no register
	localparam logic [IDX_W-1:0] REG_UNUSED = 8'hFF;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [63:0]        s_tdata;   // [63:0] data_word
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [47:0]        m_tdata;   // [1:0] frame_status, [14:2] frame_words,
	                               // [46:15] object_number, [47] zero
	logic               cfg_valid;
	logic               cfg_ready;
	logic [IDX_W-1:0]   cfg_index;
	logic [THR_W-1:0]   cfg_data;

	int                 mismatches;
	int                 outstanding;
	int                 idle_cycles;
	int                 words_sent;
	logic               calm;
	logic [THR_W-1:0]   rise_now;
	logic [THR_W-1:0]   fall_now;

	acquisition_frame_checker uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	acquisition_frame_checker_chk chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("acquisition_frame_checker_test NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_word(input logic [63:0] w);
		@(negedge clk);
		while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do @(posedge clk); while (!s_tready);
		words_sent++;
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [THR_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_RISE_THR)
			rise_now = val;
		else if (idx == REG_FALL_THR)
			fall_now = val;
	endtask

	// stop the input and let every pending result and any frame tail work drain
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_frame(input logic [LEN_W-1:0] len, input logic [7:0] trig,
			input logic [7:0] hid, input logic [31:0] thr, input logic [7:0] fid,
			input logic [31:0] obj);
		logic [63:0] noise;
		noise = {$urandom, $urandom};
		send_word({hid, noise[55:44], len, trig, noise[23:0]});
		noise = {$urandom, $urandom};
		send_word({noise[63:32], thr});
		for (int i = 0; i < len; i++)
			send_word({$urandom, $urandom});
		noise = {$urandom, $urandom};
		send_word({fid, noise[55:32], obj});
	endtask

	task automatic random_frame();
		int          pick;
		logic [LEN_W-1:0] len;
		logic [7:0]  trig;
		logic [7:0]  hid;
		logic [7:0]  fid;
		logic [31:0] thr;
		logic [31:0] obj;
		pick = $urandom_range(99);
		if (pick < 70)
			len = LEN_W'($urandom_range(6));
		else if (pick < 96)
			len = LEN_W'($urandom_range(40, 7));
		else
			len = LEN_W'($urandom_range(300, 41));
		trig = 8'($urandom);
		hid = 8'($urandom);
		if ($urandom_range(99) < 90)
			hid = HDR_MARK;
		fid = 8'($urandom);
		if ($urandom_range(99) < 90)
			fid = FTR_MARK;
		thr = {rise_now, fall_now};
		pick = $urandom_range(99);
		if (pick < 8)
			thr = thr ^ (32'h1 << $urandom_range(31));
		else if (pick < 12)
			thr = $urandom;
		obj = ($urandom_range(99) < 20) ? 32'h0 : 32'($urandom);
		send_frame(len, trig, hid, thr, fid, obj);
	endtask

	initial begin
		int phase_start;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_RISE_THR;
		cfg_data = '0;
		calm = 1'b0;
		words_sent = 0;
		rise_now = RISE_THR_RESET;
		fall_now = FALL_THR_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed frames against the reset thresholds
		send_frame(12'd0, 8'h10, HDR_MARK, {rise_now, fall_now}, FTR_MARK, 32'h1234_5678);
		// frame-continue clear: last frame
		send_frame(12'd0, 8'h00, HDR_MARK, {rise_now, fall_now}, FTR_MARK, 32'hFFFF_FFFF);
		// trigger state set with object zero
		send_frame(12'd1, 8'h70, HDR_MARK, {rise_now, fall_now}, FTR_MARK, 32'h0);
		// trigger state set but object nonzero, continue clear
		send_frame(12'd0, 8'h60, HDR_MARK, {rise_now, fall_now}, FTR_MARK, 32'h1);
		send_frame(12'd0, 8'h9F, FTR_MARK, {rise_now, fall_now}, FTR_MARK, 32'h2);
		send_frame(12'd0, 8'h10, HDR_MARK, {rise_now, ~fall_now}, FTR_MARK, 32'h3);
		send_frame(12'd0, 8'h10, HDR_MARK, {rise_now, fall_now}, HDR_MARK, 32'h4);
		// payload extremes, every header bit high around the length
		send_word({HDR_MARK, 12'hFFF, 12'd2, 8'hFF, 24'hFF_FFFF});
		send_word({32'hFFFF_FFFF, rise_now, fall_now});
		send_word(64'h0);
		send_word('1);
		send_word({FTR_MARK, 24'hFF_FFFF, 32'hFFFF_FFFF});

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			case (p)
				0: begin
					write_reg(REG_RISE_THR, 16'h0000);
					write_reg(REG_FALL_THR, 16'h0000);
				end
				1: begin
					write_reg(REG_RISE_THR, 16'hFFFF);
					write_reg(REG_FALL_THR, 16'hFFFF);
				end
				2: begin
					write_reg(REG_RISE_THR, 16'($urandom));
					write_reg(REG_FALL_THR, 16'($urandom));
					write_reg(REG_UNUSED, 16'($urandom));
				end
				3: begin
					write_reg(REG_RISE_THR, 16'hFFFF);
					write_reg(REG_FALL_THR, 16'h0000);
				end
				default: begin
					write_reg(REG_FALL_THR, 16'($urandom));
					write_reg(REG_RISE_THR, 16'($urandom));
				end
			endcase
			@(negedge clk);
			cfg_valid <= 1'b0;
			// one phase runs with the stimulus never idle and m_tready always high
			calm = (p == 2);
			if (p == 3)
				send_frame(12'd400, 8'h10, HDR_MARK, {rise_now, fall_now}, FTR_MARK,
					$urandom);
			phase_start = words_sent;
			while (words_sent - phase_start < RANDOM_ITEMS / PHASES)
				random_frame();
		end

		wait_idle();
		calm = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("acquisition_frame_checker_test OK");
		else
			$display("acquisition_frame_checker_test NOT OK");
		$finish;
	end

endmodule
